@@ sv/saq_pkg.sv @@
// Shared types and constants for the shortest-arc quaternion block.
// No dependencies; every other file imports this package.
package saq_pkg;

  localparam int THRESHOLD_SHIFT = 20;
  localparam int RAD_W     = 100;  // radicand width of a square-root chain
  localparam int ROOT_W    = 50;   // root bits, one per square-root cell
  localparam int REM_W     = 53;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int DIV_STEPS = 15;   // quotient bits, one per divide cell
  localparam logic [14:0] ONE_Q14 = 15'd16384;

  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } vec_t;

  typedef struct packed {
    logic        [14:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic               opposite;
    logic               undefined;
  } quat_t;

  // one step of the digit-by-digit square root
  typedef struct packed {
    logic [RAD_W-1:0]  n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // one step of the restoring divider
  typedef struct packed {
    logic [ROOT_W-1:0]    q;
    logic [ROOT_W-1:0]    rem;
    logic [DIV_STEPS-1:0] low;
    logic [DIV_STEPS-1:0] quo;
  } dv_t;

endpackage

@@ sv/saq_sqrt_cell.sv @@
// One cell of the square-root chain: settles one root bit per cycle.
// Depends on saq_pkg.
module saq_sqrt_cell (
  input  logic         clk,
  input  saq_pkg::sq_t prev,
  output saq_pkg::sq_t curr
);
  import saq_pkg::*;

  logic [REM_W-1:0] rem_s;
  logic [REM_W-1:0] trial;

  assign rem_s = {prev.rem[REM_W-3:0], prev.n[RAD_W-1 -: 2]};
  assign trial = {1'b0, prev.root, 2'b01};

  always_ff @(posedge clk) begin
    curr.n <= {prev.n[RAD_W-3:0], 2'b00};
    if (rem_s >= trial) begin
      curr.rem  <= rem_s - trial;
      curr.root <= {prev.root[ROOT_W-2:0], 1'b1};
    end else begin
      curr.rem  <= rem_s;
      curr.root <= {prev.root[ROOT_W-2:0], 1'b0};
    end
  end

endmodule

@@ sv/saq_div_cell.sv @@
// One cell of the restoring divider: settles one quotient bit per cycle.
// Depends on saq_pkg.
module saq_div_cell (
  input  logic         clk,
  input  saq_pkg::dv_t prev,
  output saq_pkg::dv_t curr
);
  import saq_pkg::*;

  logic [ROOT_W:0] r_s;
  logic [ROOT_W:0] qx;

  assign r_s = {prev.rem, prev.low[DIV_STEPS-1]};
  assign qx  = {1'b0, prev.q};

  always_ff @(posedge clk) begin
    curr.q   <= prev.q;
    curr.low <= {prev.low[DIV_STEPS-2:0], 1'b0};
    if (r_s >= qx) begin
      curr.rem <= ROOT_W'(r_s - qx);
      curr.quo <= {prev.quo[DIV_STEPS-2:0], 1'b1};
    end else begin
      curr.rem <= ROOT_W'(r_s);
      curr.quo <= {prev.quo[DIV_STEPS-2:0], 1'b0};
    end
  end

endmodule

@@ sv/shortest_arc_quaternion_top.sv @@
// Shortest-arc quaternion between two integer 3-vectors, fully pipelined.
// Depends on saq_pkg, saq_sqrt_cell and saq_div_cell.
//
//  channel   strobe        payload   dir
//  input     start/busy    vectors   in   (accepted when start && !busy)
//  result    done          quat      out  (valid for one cycle)
//
// One item per cycle, every cycle; busy is never raised.
// The result passes through two 50-cell square-root chains, a 15-cell divider
// chain and the single stages around them before done rises.
// Synchronous reset clears only the valid flags of the pipeline.
// The receiver cannot stall, so nothing holds the pipe.
module shortest_arc_quaternion_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  saq_pkg::vec_t  vectors,
  output logic           done,
  output saq_pkg::quat_t quat
);
  import saq_pkg::*;

  typedef struct packed {
    logic               undef;
    logic signed [32:0] d;
    logic signed [32:0] cx;
    logic signed [32:0] cy;
    logic signed [32:0] cz;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
  } sb1_t;

  typedef struct packed {
    logic              undef;
    logic              opp;
    logic              sx;
    logic              sy;
    logic              sz;
    logic [ROOT_W-1:0] mw;
    logic [31:0]       mx;
    logic [31:0]       my;
    logic [31:0]       mz;
  } sb2_t;

  typedef struct packed {
    logic undef;
    logic opp;
    logic sx;
    logic sy;
    logic sz;
  } sb3_t;

  assign busy = 1'b0;

  // stage 1: capture
  logic v1;
  vec_t in1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy;
    in1 <= vectors;
  end

  // stage 2: products
  logic v2;
  logic signed [31:0] pu0, pu1, pu2, pv0, pv1, pv2, pd0, pd1, pd2;
  logic signed [31:0] c0a, c0b, c1a, c1b, c2a, c2b;
  logic signed [15:0] ux2, uy2, uz2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    pu0 <= in1.ux * in1.ux; pu1 <= in1.uy * in1.uy; pu2 <= in1.uz * in1.uz;
    pv0 <= in1.vx * in1.vx; pv1 <= in1.vy * in1.vy; pv2 <= in1.vz * in1.vz;
    pd0 <= in1.ux * in1.vx; pd1 <= in1.uy * in1.vy; pd2 <= in1.uz * in1.vz;
    c0a <= in1.uy * in1.vz; c0b <= in1.uz * in1.vy;
    c1a <= in1.uz * in1.vx; c1b <= in1.ux * in1.vz;
    c2a <= in1.ux * in1.vy; c2b <= in1.uy * in1.vx;
    ux2 <= in1.ux; uy2 <= in1.uy; uz2 <= in1.uz;
  end

  // stage 3: sums
  logic v3;
  logic [31:0] nu3, nv3;
  sb1_t sb3r;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    nu3 <= $unsigned(pu0) + $unsigned(pu1) + $unsigned(pu2);
    nv3 <= $unsigned(pv0) + $unsigned(pv1) + $unsigned(pv2);
    // squares are never negative, so a zero norm means every square is zero
    sb3r.undef <= ((pu0 | pu1 | pu2) == 32'sd0) || ((pv0 | pv1 | pv2) == 32'sd0);
    sb3r.d  <= {pd0[31], pd0} + {pd1[31], pd1} + {pd2[31], pd2};
    sb3r.cx <= {c0a[31], c0a} - {c0b[31], c0b};
    sb3r.cy <= {c1a[31], c1a} - {c1b[31], c1b};
    sb3r.cz <= {c2a[31], c2a} - {c2b[31], c2b};
    sb3r.ux <= ux2; sb3r.uy <= uy2; sb3r.uz <= uz2;
  end

  // stage 4: norm product
  logic v4;
  logic [63:0] p4;
  sb1_t sb4r;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    p4 <= nu3 * nv3;
    sb4r <= sb3r;
  end

  // first square root: |u||v| with 16 fraction bits
  sq_t  ch1 [0:SQ_STEPS];
  sb1_t sq1 [0:SQ_STEPS];
  logic [SQ_STEPS:0] vq1;

  assign ch1[0] = '{n: {4'b0, p4, 32'b0}, rem: '0, root: '0};
  assign sq1[0] = sb4r;
  assign vq1[0] = v4;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq1
    saq_sqrt_cell u_cell (.clk(clk), .prev(ch1[k]), .curr(ch1[k+1]));
    always_ff @(posedge clk) begin
      sq1[k+1] <= sq1[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vq1[SQ_STEPS:1] <= '0;
    else     vq1[SQ_STEPS:1] <= vq1[SQ_STEPS-1:0];
  end

  // stage 5: real part and threshold
  logic [ROOT_W-1:0] mroot;
  logic signed [ROOT_W+1:0] wr;
  logic [ROOT_W:0] csum;
  assign mroot = ch1[SQ_STEPS].root;
  assign wr = $signed({2'b00, mroot})
            + $signed({{3{sq1[SQ_STEPS].d[32]}}, sq1[SQ_STEPS].d, 16'b0});
  assign csum = {1'b0, mroot} + (ROOT_W+1)'((64'd1 << THRESHOLD_SHIFT) - 64'd1);

  logic v5;
  logic [ROOT_W-1:0] w5;
  logic [ROOT_W:0] ceil5;
  sb1_t sb5r;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= vq1[SQ_STEPS];
    w5    <= wr[ROOT_W+1] ? '0 : wr[ROOT_W-1:0];
    ceil5 <= csum >> THRESHOLD_SHIFT;
    sb5r  <= sq1[SQ_STEPS];
  end

  // stage 6: opposite test, axis choice, magnitudes
  logic opp6c, xbig;
  logic [16:0] aux, auz;
  logic signed [32:0] x6c, y6c, z6c;
  assign opp6c = {1'b0, w5} < ceil5;
  assign aux = sb5r.ux[15] ? 17'd0 - {1'b1, sb5r.ux} : {1'b0, sb5r.ux};
  assign auz = sb5r.uz[15] ? 17'd0 - {1'b1, sb5r.uz} : {1'b0, sb5r.uz};
  assign xbig = aux > auz;

  always_comb begin
    if (!opp6c) begin
      x6c = sb5r.cx; y6c = sb5r.cy; z6c = sb5r.cz;
    end else if (xbig) begin
      x6c = 33'sd0 - {{17{sb5r.uy[15]}}, sb5r.uy};
      y6c = {{17{sb5r.ux[15]}}, sb5r.ux};
      z6c = '0;
    end else begin
      x6c = '0;
      y6c = 33'sd0 - {{17{sb5r.uz[15]}}, sb5r.uz};
      z6c = {{17{sb5r.uy[15]}}, sb5r.uy};
    end
  end

  logic v6;
  sb2_t sb6r;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    sb6r.undef <= sb5r.undef;
    sb6r.opp   <= opp6c;
    sb6r.mw    <= opp6c ? '0 : w5;
    sb6r.sx <= x6c[32]; sb6r.sy <= y6c[32]; sb6r.sz <= z6c[32];
    sb6r.mx <= x6c[32] ? 32'(33'sd0 - x6c) : x6c[31:0];
    sb6r.my <= y6c[32] ? 32'(33'sd0 - y6c) : y6c[31:0];
    sb6r.mz <= z6c[32] ? 32'(33'sd0 - z6c) : z6c[31:0];
  end

  // stage 7: squares, the real part split into halves
  logic v7;
  logic [49:0] paa, pab, pbb;
  logic [63:0] px, py, pz;
  sb2_t sb7r;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    paa <= sb6r.mw[49:25] * sb6r.mw[49:25];
    pab <= sb6r.mw[49:25] * sb6r.mw[24:0];
    pbb <= sb6r.mw[24:0] * sb6r.mw[24:0];
    px  <= sb6r.mx * sb6r.mx;
    py  <= sb6r.my * sb6r.my;
    pz  <= sb6r.mz * sb6r.mz;
    sb7r <= sb6r;
  end

  // stage 8 and 9: sum of squares
  logic v8, v9;
  logic [RAD_W-1:0] sw8, sum9;
  logic [65:0] sv8;
  sb2_t sb8r, sb9r;
  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      v8 <= v7;
      v9 <= v8;
    end
    // cross term 2ab lands at bit 25 + 1
    sw8  <= {paa, 50'b0} + {24'b0, pab, 26'b0} + {50'b0, pbb};
    sv8  <= {2'b0, px} + {2'b0, py} + {2'b0, pz};
    sb8r <= sb7r;
    sum9 <= sw8 + {2'b0, sv8, 32'b0};
    sb9r <= sb8r;
  end

  // second square root: norm of the raw quaternion
  sq_t  ch2 [0:SQ_STEPS];
  sb2_t sq2 [0:SQ_STEPS];
  logic [SQ_STEPS:0] vq2;

  assign ch2[0] = '{n: sum9, rem: '0, root: '0};
  assign sq2[0] = sb9r;
  assign vq2[0] = v9;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq2
    saq_sqrt_cell u_cell (.clk(clk), .prev(ch2[k]), .curr(ch2[k+1]));
    always_ff @(posedge clk) begin
      sq2[k+1] <= sq2[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vq2[SQ_STEPS:1] <= '0;
    else     vq2[SQ_STEPS:1] <= vq2[SQ_STEPS-1:0];
  end

  // stage 10: dividends with half-divisor rounding
  logic [ROOT_W-1:0] qn;
  logic [ROOT_W-1:0] lmag [0:3];
  logic [64:0] num [0:3];
  assign qn = ch2[SQ_STEPS].root;
  assign lmag[0] = sq2[SQ_STEPS].mw;
  assign lmag[1] = {2'b0, sq2[SQ_STEPS].mx, 16'b0};
  assign lmag[2] = {2'b0, sq2[SQ_STEPS].my, 16'b0};
  assign lmag[3] = {2'b0, sq2[SQ_STEPS].mz, 16'b0};

  dv_t  dch [0:3][0:DIV_STEPS];
  sb3_t sd  [0:DIV_STEPS];
  logic [DIV_STEPS:0] vd;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign num[l] = {1'b0, lmag[l], 14'b0} + {15'b0, qn >> 1};
    always_ff @(posedge clk) begin
      dch[l][0] <= '{q: qn, rem: num[l][64:15], low: num[l][14:0], quo: '0};
    end
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      saq_div_cell u_cell (.clk(clk), .prev(dch[l][k]), .curr(dch[l][k+1]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vd <= '0;
    else     vd <= {vd[DIV_STEPS-1:0], vq2[SQ_STEPS]};
    sd[0] <= '{undef: sq2[SQ_STEPS].undef, opp: sq2[SQ_STEPS].opp,
               sx: sq2[SQ_STEPS].sx, sy: sq2[SQ_STEPS].sy, sz: sq2[SQ_STEPS].sz};
    for (int k = 0; k < DIV_STEPS; k++) sd[k+1] <= sd[k];
  end

  // stage 11: clamp, sign, output
  logic [14:0] rq [0:3];
  for (genvar l = 0; l < 4; l++) begin : g_sat
    assign rq[l] = (dch[l][DIV_STEPS].quo > ONE_Q14) ? ONE_Q14 : dch[l][DIV_STEPS].quo;
  end

  sb3_t fin;
  assign fin = sd[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vd[DIV_STEPS];
    if (fin.undef) begin
      quat <= '{qw: '0, qx: '0, qy: '0, qz: '0, opposite: 1'b0, undefined: 1'b1};
    end else begin
      quat.qw <= rq[0];
      quat.qx <= fin.sx ? 16'sd0 - {1'b0, rq[1]} : {1'b0, rq[1]};
      quat.qy <= fin.sy ? 16'sd0 - {1'b0, rq[2]} : {1'b0, rq[2]};
      quat.qz <= fin.sz ? 16'sd0 - {1'b0, rq[3]} : {1'b0, rq[3]};
      quat.opposite  <= fin.opp;
      quat.undefined <= 1'b0;
    end
  end

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    done && quat.undefined |-> quat.qw == 15'd0 && quat.qx == 16'sd0 &&
      quat.qy == 16'sd0 && quat.qz == 16'sd0 && !quat.opposite)
    else $error("undefined item with nonzero payload");

  a_opp_real: assert property (@(posedge clk) disable iff (rst)
    done && quat.opposite |-> quat.qw == 15'd0)
    else $error("opposite item with nonzero real part");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> quat.qw <= ONE_Q14)
    else $error("real part above one");

endmodule

@@ tb/shortest_arc_quaternion_top_tb.sv @@
// Testbench for shortest_arc_quaternion_top: directed and random vector pairs,
// results predicted in wide integer arithmetic and checked in order.
// Depends on saq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module shortest_arc_quaternion_top_tb;
  import saq_pkg::*;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  vec_t  vectors = '0;
  logic  done;
  quat_t quat;

  vec_t  pending_q[$];
  quat_t expected_q[$];
  int    errors = 0;
  int    gap_left = 0;
  bit    stim_done = 1'b0;

  shortest_arc_quaternion_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vectors(vectors), .done(done), .quat(quat)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] round_q14(logic signed [63:0] c,
                                                    logic [63:0] q);
    logic [127:0] m;
    logic [127:0] r;
    if (q == 0) return '0;
    m = (c < 0) ? -c : c;
    r = ((m << 14) + (q >> 1)) / q;
    if (r > 16384) r = 16384;
    return (c < 0) ? -r[15:0] : r[15:0];
  endfunction

  function automatic quat_t rotation_between(vec_t v);
    quat_t               res;
    logic signed [63:0]  ux, uy, uz, vx, vy, vz, d, w, x, y, z;
    logic [63:0]         nu, nv, m, q, ceilm, aux, auz, ax, ay, az;
    logic [127:0]        sum;
    res = '0;
    ux = v.ux; uy = v.uy; uz = v.uz; vx = v.vx; vy = v.vy; vz = v.vz;
    nu = ux * ux + uy * uy + uz * uz;
    nv = vx * vx + vy * vy + vz * vz;
    if (nu == 0 || nv == 0) begin
      res.undefined = 1'b1;
      return res;
    end
    m = isqrt128({64'd0, nu * nv} << 32);
    d = ux * vx + uy * vy + uz * vz;
    w = $signed(m) + d * 65536;
    if (w < 0) w = 0;
    ceilm = (m + ((64'd1 << THRESHOLD_SHIFT) - 1)) >> THRESHOLD_SHIFT;
    if (w < $signed(ceilm)) begin
      res.opposite = 1'b1;
      w = 0;
      aux = (ux < 0) ? -ux : ux;
      auz = (uz < 0) ? -uz : uz;
      if (aux > auz) begin
        x = -uy; y = ux; z = 0;
      end else begin
        x = 0; y = -uz; z = uy;
      end
    end else begin
      x = uy * vz - uz * vy;
      y = uz * vx - ux * vz;
      z = ux * vy - uy * vx;
    end
    x = x * 65536; y = y * 65536; z = z * 65536;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    sum = {64'd0, w} * {64'd0, w};
    sum = sum + {64'd0, ax} * {64'd0, ax};
    sum = sum + {64'd0, ay} * {64'd0, ay};
    sum = sum + {64'd0, az} * {64'd0, az};
    q = isqrt128(sum);
    res.qw = 15'(round_q14(w, q));
    res.qx = round_q14(x, q);
    res.qy = round_q14(y, q);
    res.qz = round_q14(z, q);
    return res;
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // driver: start stays high across back-to-back items
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_q.size() > 0) begin
      vectors <= pending_q[0];
      expected_q.push_back(rotation_between(pending_q[0]));
      pending_q.pop_front();
      start <= 1'b1;
      gap_left <= rand_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, quat);
        errors++;
      end else begin
        exp_q = expected_q.pop_front();
        if (quat !== exp_q) begin
          $display("%0t: mismatch expected qw=%0d qx=%0d qy=%0d qz=%0d opp=%b und=%b",
                   $time, exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz,
                   exp_q.opposite, exp_q.undefined);
          $display("%0t:          actual qw=%0d qx=%0d qy=%0d qz=%0d opp=%b und=%b",
                   $time, quat.qw, quat.qx, quat.qy, quat.qz,
                   quat.opposite, quat.undefined);
          errors++;
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("shortest_arc_quaternion_top test failed");
      $finish;
    end
  end

  initial begin
    vec_t v;
    int   k;
    // directed: zero vectors, parallel, opposite (both axis choices), extremes
    pending_q.push_back('{0, 0, 0, 1, 2, 3});
    pending_q.push_back('{1, 2, 3, 0, 0, 0});
    pending_q.push_back('{0, 0, 0, 0, 0, 0});
    pending_q.push_back('{1, 0, 0, 1, 0, 0});
    pending_q.push_back('{1, 0, 0, 0, 1, 0});
    pending_q.push_back('{5, 1, 2, -5, -1, -2});
    pending_q.push_back('{1, 3, 7, -1, -3, -7});
    pending_q.push_back('{0, 9, 0, 0, -9, 0});
    pending_q.push_back('{-32768, -32768, -32768, 32767, 32767, 32767});
    pending_q.push_back('{-32768, -32768, -32768, -32768, -32768, -32768});
    pending_q.push_back('{32767, 32767, 32767, -32768, -32768, -32768});
    pending_q.push_back('{-32768, 0, 0, 0, 0, 32767});
    pending_q.push_back('{-1, -1, -1, 32767, -32768, 1});
    pending_q.push_back('{1000, 0, 1, -1000, 0, -1});
    pending_q.push_back('{3, -4, 3, -3, 4, -3});
    for (k = 0; k < 600; k++) begin
      v.ux = rand_comp(); v.uy = rand_comp(); v.uz = rand_comp();
      case ($urandom_range(0, 4))
        0: begin // exactly or near opposite
          v.vx = -v.ux; v.vy = -v.uy; v.vz = -v.uz;
          if ($urandom_range(0, 1)) v.vz = v.vz + 16'($urandom_range(0, 2)) - 16'd1;
        end
        1: begin // scaled parallel
          v.ux = v.ux >>> 4; v.uy = v.uy >>> 4; v.uz = v.uz >>> 4;
          v.vx = v.ux * 16'sd3; v.vy = v.uy * 16'sd3; v.vz = v.uz * 16'sd3;
        end
        default: begin
          v.vx = rand_comp(); v.vy = rand_comp(); v.vz = rand_comp();
        end
      endcase
      pending_q.push_back(v);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("shortest_arc_quaternion_top test passed");
    else
      $display("shortest_arc_quaternion_top test failed");
    $finish;
  end

endmodule
